// ===== hw/rtl/tli_pkg.sv =====
// shared constants, codes and command/status types of the table interpolator
`timescale 1ns / 1ps

package tli_pkg;

  // table geometry; point_index addresses the whole table
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;

  // stream widths
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;

  // input word layout inside s_tdata
  localparam int IDX_LSB   = 0;
  localparam int PTIME_LSB = IDX_LSB + ADDR_W;
  localparam int PVAL_LSB  = PTIME_LSB + DATA_W;
  localparam int QTIME_LSB = PVAL_LSB + DATA_W;

  // serial divider
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_PAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd3;

  // padding modes
  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_FIXED = 2'd1;
  localparam logic [1:0] PAD_TABLE = 2'd2;

  // table read address select
  localparam logic [2:0] RA_FIRST = 3'd0;
  localparam logic [2:0] RA_LAST  = 3'd1;
  localparam logic [2:0] RA_MID   = 3'd2;
  localparam logic [2:0] RA_LO    = 3'd3;
  localparam logic [2:0] RA_HI    = 3'd4;

  // result select
  localparam logic [1:0] RES_LOAD   = 2'd0;
  localparam logic [1:0] RES_TABLE  = 2'd1;
  localparam logic [1:0] RES_RANGE  = 2'd2;
  localparam logic [1:0] RES_INTERP = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       do_load;
    logic [2:0] rd_sel;
    logic       cap_lo;
    logic       cap_hi;
    logic       search_init;
    logic       search_step;
    logic       diff;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       res_we;
    logic [1:0] res_sel;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_query;
    logic tbl_err;
    logic out_of_range;
    logic search_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/table_linear_interpolator.sv =====
// top level: piecewise linear table interpolator
// accept to result: a load or table error is staged in decode, an out-of-range query after
// reading the first and last points, others by binary search on one read port and a 32-step divide
// one word in work; the input opens again in the cycle after result load, even while it waits
// reset (synchronous, rst high) clears config and load state; the table needs reloading
`timescale 1ns / 1ps

module table_linear_interpolator
  import tli_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // point_index, point_time, point_value, query_time
  input  logic [0:0]           s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // value
  output logic [STATUS_W-1:0]  m_tuser,   // status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tli_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hw/rtl/tli_ctrl.sv =====
// sequencing state machine of the table interpolator
`timescale 1ns / 1ps

module tli_ctrl
  import tli_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_RD_FIRST = 5'd2;
  localparam logic [4:0] S_RD_LAST  = 5'd3;
  localparam logic [4:0] S_CAP_LAST = 5'd4;
  localparam logic [4:0] S_RANGE    = 5'd5;
  localparam logic [4:0] S_SEARCH   = 5'd6;
  localparam logic [4:0] S_PROBE    = 5'd7;
  localparam logic [4:0] S_RD_HI    = 5'd8;
  localparam logic [4:0] S_CAP_HI   = 5'd9;
  localparam logic [4:0] S_DIFF     = 5'd10;
  localparam logic [4:0] S_MUL      = 5'd11;
  localparam logic [4:0] S_ADD      = 5'd12;
  localparam logic [4:0] S_DIV      = 5'd13;
  localparam logic [4:0] S_FIN      = 5'd14;
  localparam logic [4:0] S_OUT      = 5'd15;

  logic [4:0] state;
  logic [4:0] state_next;

  assign s_tready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RA_FIRST;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_query) begin
          cmd.do_load = 1'b1;
          cmd.res_we  = 1'b1;
          cmd.res_sel = RES_LOAD;
          state_next  = S_OUT;
        end else if (sts.tbl_err) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = RES_TABLE;
          state_next  = S_OUT;
        end else begin
          state_next = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.rd_sel = RA_FIRST;
        state_next = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.rd_sel = RA_LAST;
        cmd.cap_lo = 1'b1;
        state_next = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd.cap_hi = 1'b1;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        if (sts.out_of_range) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = RES_RANGE;
          state_next  = S_OUT;
        end else begin
          cmd.search_init = 1'b1;
          state_next      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!sts.search_done) begin
          cmd.rd_sel = RA_MID;
          state_next = S_PROBE;
        end else begin
          cmd.rd_sel = RA_LO;
          state_next = S_RD_HI;
        end
      end
      S_PROBE: begin
        cmd.search_step = 1'b1;
        state_next      = S_SEARCH;
      end
      S_RD_HI: begin
        cmd.rd_sel = RA_HI;
        cmd.cap_lo = 1'b1;
        state_next = S_CAP_HI;
      end
      S_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_we  = 1'b1;
        cmd.res_sel = RES_INTERP;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tli_dp.sv =====
// datapath: config registers, table memories, search, multiply and serial divide
`timescale 1ns / 1ps

module tli_dp
  import tli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [M_TDATA_W-1:0]  m_tdata,   // value
  output logic [STATUS_W-1:0]   m_tuser,   // status
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  // configuration
  logic [1:0]        pad_mode;
  logic [DATA_W-1:0] left_pad;
  logic [DATA_W-1:0] right_pad;
  logic [CNT_W-1:0]  point_count;

  // captured word
  logic              req_type;
  logic [ADDR_W-1:0] pidx;
  logic [DATA_W-1:0] ptime;
  logic [DATA_W-1:0] pvalue;
  logic [DATA_W-1:0] qtime;

  // table state
  logic [DATA_W-1:0] time_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0] value_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]  loaded_points;
  logic [DATA_W-1:0] previous_time;
  logic              order_good;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rd_time;
  logic [DATA_W-1:0] rd_value;

  // search and arithmetic
  logic [ADDR_W-1:0]    lo;
  logic [ADDR_W-1:0]    hi;
  logic [ADDR_W-1:0]    span;
  logic [ADDR_W-1:0]    mid;
  logic [DATA_W-1:0]    t0;
  logic [DATA_W-1:0]    t1;
  logic [DATA_W-1:0]    v0;
  logic [DATA_W-1:0]    v1;
  logic                 neg;
  logic [DATA_W-1:0]    mag;
  logic [DATA_W-1:0]    dq;
  logic [DATA_W-1:0]    dt;
  logic [2*DATA_W-1:0]  prod;
  logic [2*DATA_W-1:0]  numer;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DATA_W:0]      dv_c;
  logic [DATA_W:0]      mag_c;
  logic [DATA_W:0]      dq_c;
  logic [DATA_W:0]      dt_c;
  logic [DATA_W+1:0]    trial;

  // load bookkeeping
  logic [CNT_W-1:0] eff_loaded;
  logic             load_ok;
  logic             unsorted;

  // result staging and output register
  logic [DATA_W-1:0]   res_value;
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   range_value;
  logic [STATUS_W-1:0] range_status;
  logic                left_side;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode    <= PAD_NONE;
      left_pad    <= '0;
      right_pad   <= '0;
      point_count <= CNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAD_MODE:    pad_mode    <= cfg_data[1:0];
        CFG_LEFT_PAD:    left_pad    <= cfg_data;
        CFG_RIGHT_PAD:   right_pad   <= cfg_data;
        CFG_POINT_COUNT: point_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= s_tuser[0];
      pidx     <= s_tdata[IDX_LSB +: ADDR_W];
      ptime    <= s_tdata[PTIME_LSB +: DATA_W];
      pvalue   <= s_tdata[PVAL_LSB +: DATA_W];
      qtime    <= s_tdata[QTIME_LSB +: DATA_W];
    end
  end

  // load acceptance: index zero restarts the table
  assign eff_loaded = (pidx == '0) ? '0 : loaded_points;
  assign load_ok    = ({1'b0, pidx} == eff_loaded);
  assign unsorted   = (eff_loaded != '0) && ($signed(ptime) <= $signed(previous_time));

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_points <= '0;
      previous_time <= '0;
      order_good    <= 1'b1;
    end else if (cmd.do_load && load_ok) begin
      loaded_points <= eff_loaded + CNT_W'(1);
      previous_time <= ptime;
      order_good    <= (pidx == '0) || (order_good && !unsorted);
    end
  end

  // table memories, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_load && load_ok) begin
      time_mem[pidx]  <= ptime;
      value_mem[pidx] <= pvalue;
    end
    rd_time  <= time_mem[raddr];
    rd_value <= value_mem[raddr];
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RA_FIRST: raddr = '0;
      RA_LAST:  raddr = point_count[ADDR_W-1:0] - ADDR_W'(1);
      RA_MID:   raddr = mid;
      RA_LO:    raddr = lo;
      RA_HI:    raddr = hi;
      default:  raddr = '0;
    endcase
  end

  // bracket registers
  assign span = hi - lo;
  assign mid  = lo + (span >> 1);

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= point_count[ADDR_W-1:0] - ADDR_W'(1);
    end else if (cmd.search_step) begin
      if ($signed(rd_time) <= $signed(qtime)) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
  end

  // endpoint capture
  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      t0 <= rd_time;
      v0 <= rd_value;
    end
    if (cmd.cap_hi) begin
      t1 <= rd_time;
      v1 <= rd_value;
    end
  end

  // differences
  assign dv_c  = {v1[DATA_W-1], v1} - {v0[DATA_W-1], v0};
  assign mag_c = dv_c[DATA_W] ? (~dv_c + (DATA_W+1)'(1)) : dv_c;
  assign dq_c  = {qtime[DATA_W-1], qtime} - {t0[DATA_W-1], t0};
  assign dt_c  = {t1[DATA_W-1], t1} - {t0[DATA_W-1], t0};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg <= dv_c[DATA_W];
      mag <= mag_c[DATA_W-1:0];
      dq  <= dq_c[DATA_W-1:0];
      dt  <= dt_c[DATA_W-1:0];
    end
    if (cmd.mul) begin
      prod <= mag * dq;
    end
  end

  // restoring divider; the quotient is known to fit one word
  assign numer = prod + (2*DATA_W)'(dt[DATA_W-1:1]);
  assign trial = {1'b0, rem, quo[DATA_W-1]} - {2'b00, dt};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= numer[2*DATA_W-1:DATA_W];
      quo     <= numer[DATA_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DATA_W+1]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // out-of-range result, t0/v0 and t1/v1 hold the first and last points here
  assign left_side = $signed(qtime) < $signed(t0);

  always_comb begin
    case (pad_mode)
      PAD_NONE: begin
        range_value  = '0;
        range_status = ST_RANGE;
      end
      PAD_TABLE: begin
        range_value  = left_side ? v0 : v1;
        range_status = ST_OK;
      end
      default: begin
        range_value  = left_side ? left_pad : right_pad;
        range_status = ST_OK;
      end
    endcase
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      case (cmd.res_sel)
        RES_LOAD: begin
          res_value  <= '0;
          res_status <= ST_OK;
        end
        RES_TABLE: begin
          res_value  <= '0;
          res_status <= ST_TABLE;
        end
        RES_RANGE: begin
          res_value  <= range_value;
          res_status <= range_status;
        end
        RES_INTERP: begin
          res_value  <= neg ? (v0 - quo) : (v0 + quo);
          res_status <= ST_OK;
        end
        default: begin
          res_value  <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

  // status to controller
  assign sts.is_query     = (req_type == REQ_QUERY);
  assign sts.tbl_err      = (point_count < CNT_W'(2)) ||
                            (point_count > CNT_W'(TABLE_DEPTH)) ||
                            (loaded_points < point_count) || !order_good;
  assign sts.out_of_range = left_side || ($signed(qtime) > $signed(t1));
  assign sts.search_done  = (span <= ADDR_W'(1));
  assign sts.div_done     = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_free     = !m_tvalid || m_tready;

endmodule

// ===== hw/rtl/tli_checker.sv =====
// port-level checks of the table interpolator and their bind
`timescale 1ns / 1ps

module tli_checker
  import tli_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [0:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]  m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_RANGE) || (m_tuser == ST_TABLE))
    else $error("undefined status code");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result with nonzero value");

  // one word in work: input closes right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

  // a load still holds the input closed in the output state that follows decode
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD) |=> ##1 !s_tready)
    else $error("load finished too early");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_table_linear_interpolator.sv =====
// testbench for the piecewise linear table interpolator: directed and random words
`timescale 1ns / 1ps

module tb_table_linear_interpolator;
  import tli_pkg::*;

  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_WORDS  = 300;
  localparam int LARGE_POINTS  = 128;
  localparam int MAX_REPORTS   = 10;
  localparam int RESET_POINTS  = 2;

  // pad mode three behaves like fixed padding
  localparam logic [1:0] PAD_FIXED_ALT = 2'd3;

  localparam longint TIME_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } lerp_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [0:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // expected results, oldest first
  lerp_result_t pending_results[$];
  int           mismatches   = 0;
  int           results_seen = 0;
  int           cycle_count  = 0;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  // predictor copy of registers and table state
  logic [1:0]               pad_sel        = PAD_NONE;
  logic signed [DATA_W-1:0] pad_left       = '0;
  logic signed [DATA_W-1:0] pad_right      = '0;
  logic [CNT_W-1:0]         points_used    = CNT_W'(RESET_POINTS);
  int unsigned              points_loaded  = 0;
  logic signed [DATA_W-1:0] last_load_time = '0;
  logic                     table_sorted   = 1'b1;
  logic signed [DATA_W-1:0] tbl_time  [TABLE_DEPTH];
  logic signed [DATA_W-1:0] tbl_value [TABLE_DEPTH];

  // times of the table most recently sent, for picking query times
  longint gen_times[$];

  table_linear_interpolator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= !stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // expected result of one accepted word; updates the table copy on loads
  function automatic lerp_result_t predict_result(logic req, logic [ADDR_W-1:0] idx,
                                                  logic signed [DATA_W-1:0] pt, pv, q);
    lerp_result_t r;
    int unsigned  n, lo, hi, mid;
    longint       t0, t1, v0, v1, dv;
    bit [63:0]    mag, dq, dt, inc;
    r.value  = '0;
    r.status = ST_OK;
    // load: index zero restarts, only the next index in sequence is stored
    if (req == REQ_LOAD) begin
      if (idx == 0) begin
        points_loaded = 0;
        table_sorted  = 1'b1;
      end
      if (idx == points_loaded) begin
        if (points_loaded > 0 && pt <= last_load_time) table_sorted = 1'b0;
        tbl_time[idx]  = pt;
        tbl_value[idx] = pv;
        last_load_time = pt;
        points_loaded++;
      end
      return r;
    end
    n = 32'(points_used);
    if (n < 2 || n > TABLE_DEPTH || points_loaded < n || !table_sorted) begin
      r.status = ST_TABLE;
      return r;
    end
    // outside the table time range
    if (q < tbl_time[0] || q > tbl_time[n - 1]) begin
      case (pad_sel)
        PAD_NONE:  r.status = ST_RANGE;
        PAD_TABLE: r.value  = (q < tbl_time[0]) ? tbl_value[0] : tbl_value[n - 1];
        default:   r.value  = (q < tbl_time[0]) ? pad_left : pad_right;
      endcase
      return r;
    end
    // bracket by binary search
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_time[mid] <= q) lo = mid;
      else hi = mid;
    end
    // rounded increment, ties away from zero
    t0  = tbl_time[lo];
    t1  = tbl_time[hi];
    v0  = tbl_value[lo];
    v1  = tbl_value[hi];
    dv  = v1 - v0;
    mag = (dv < 0) ? -dv : dv;
    dq  = q - t0;
    dt  = t1 - t0;
    inc = (mag * dq + dt / 2) / dt;
    r.value = 32'((dv < 0) ? v0 - longint'(inc) : v0 + longint'(inc));
    return r;
  endfunction

  // register writes, result checks and predictions, all sampled at the rising edge
  always @(posedge clk) begin : scoreboard
    lerp_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAD_MODE:    pad_sel     = cfg_data[1:0];
          CFG_LEFT_PAD:    pad_left    = cfg_data;
          CFG_RIGHT_PAD:   pad_right   = cfg_data;
          CFG_POINT_COUNT: points_used = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected none, got value %h status %0d",
                     results_seen, m_tdata, m_tuser);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== want.value || m_tuser !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected value %h status %0d, got value %h status %0d",
                       results_seen, want.value, want.status, m_tdata, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_result(s_tuser[0], s_tdata[IDX_LSB +: ADDR_W],
                              s_tdata[PTIME_LSB +: DATA_W], s_tdata[PVAL_LSB +: DATA_W],
                              s_tdata[QTIME_LSB +: DATA_W]);
        pending_results = {pending_results, want};
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // one input word, with random idle cycles ahead of it when gaps are on
  task automatic send_word(input logic req, input logic [ADDR_W-1:0] idx,
                           input logic [DATA_W-1:0] pt, pv, qt);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata                        = '0;
    s_tdata[IDX_LSB +: ADDR_W]     = idx;
    s_tdata[PTIME_LSB +: DATA_W]   = pt;
    s_tdata[PVAL_LSB +: DATA_W]    = pv;
    s_tdata[QTIME_LSB +: DATA_W]   = qt;
    s_tuser                        = req;
    s_tvalid                       = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // unused fields carry random bits
  task automatic send_point(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] t, v);
    send_word(REQ_LOAD, idx, t, v, $urandom);
  endtask

  task automatic send_query(input logic [DATA_W-1:0] q);
    send_word(REQ_QUERY, ADDR_W'($urandom), $urandom, $urandom, q);
  endtask

  // stop sending and wait until every result is back and the block has settled
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only once the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // query time: mostly inside the table, some on or beside points, some anywhere, some just outside
  function automatic logic [DATA_W-1:0] pick_query_time();
    longint first_t, last_t;
    int     k;
    first_t = gen_times[0];
    last_t  = gen_times[gen_times.size() - 1];
    k       = $urandom_range(0, 99);
    if (k < 50) return 32'(first_t + $urandom_range(0, 32'(last_t - first_t)));
    if (k < 70)
      return 32'(gen_times[$urandom_range(0, gen_times.size() - 1)] + $urandom_range(0, 2) - 1);
    if (k < 90) return $urandom;
    return $urandom_range(0, 1) ? 32'(first_t - 1) : 32'(last_t + 1);
  endfunction

  // sorted table of n points with random spacing; noise adds stray and unsorted words
  task automatic load_table(input int n, input int noise_pct);
    longint            step_max, total, t;
    longint            steps[$];
    logic [DATA_W-1:0] v;
    int                i, stray;
    case ($urandom_range(0, 2))
      0:       step_max = 4;
      1:       step_max = 1000;
      default: step_max = 64'h1_0000_0000 / n;
    endcase
    total = 0;
    for (i = 1; i < n; i++) begin
      steps = {steps, longint'($urandom_range(1, 32'(step_max)))};
      total += steps[i - 1];
    end
    t = TIME_MIN + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - total)));
    v = $urandom;
    gen_times = {};
    for (i = 0; i < n; i++) begin
      if (i > 0) begin
        t += steps[i - 1];
        v = $urandom_range(0, 1) ? $urandom : v + $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
      end
      if (i > 0 && $urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1)) begin
          // out of sequence, dropped by the block
          stray = $urandom_range(1, TABLE_DEPTH - 2);
          if (stray >= i) stray++;
          send_point(ADDR_W'(stray), $urandom, $urandom);
        end else begin
          // repeated time breaks the ordering
          t = gen_times[i - 1];
        end
      end
      send_point(ADDR_W'(i), 32'(t), v);
      gen_times = {gen_times, t};
      if ($urandom_range(0, 99) < 3) send_query(pick_query_time());
    end
  endtask

  // extremes of time and value, empty and partial table, stray index
  task automatic test_extremes();
    send_query($urandom);
    send_point(ADDR_W'(0), 32'h8000_0000, 32'h8000_0000);
    send_point(ADDR_W'(TABLE_DEPTH - 1), $urandom, $urandom);
    send_query($urandom);
    send_point(ADDR_W'(1), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h0000_0000);
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
  endtask

  // each padding mode, on both sides except for mode three, restart at index zero
  task automatic test_padding_modes();
    write_reg(CFG_PAD_MODE, 32'hFFFF_FFFC);
    send_point(ADDR_W'(0), -32'sd100, 32'h0001_0000);
    send_point(ADDR_W'(1), 32'sd100, 32'hFFFD_0000);
    send_query(-32'sd101);
    send_query(32'sd101);
    write_reg(CFG_PAD_MODE, DATA_W'(PAD_FIXED));
    write_reg(CFG_LEFT_PAD, 32'h8000_0000);
    write_reg(CFG_RIGHT_PAD, 32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'h7FFF_FFFF);
    write_reg(CFG_PAD_MODE, DATA_W'(PAD_TABLE));
    send_query(-32'sd150);
    send_query(32'sd150);
    write_reg(CFG_PAD_MODE, DATA_W'(PAD_FIXED_ALT));
    send_query(-32'sd101);
    send_query(32'sd1);
  endtask

  // unsorted table, rounding ties, bad point counts and ignored register indexes
  task automatic test_order_and_count();
    int k;
    send_point(ADDR_W'(0), 32'sd10, 32'sd0);
    send_point(ADDR_W'(1), 32'sd10, 32'sd5);
    send_query(32'sd10);
    send_point(ADDR_W'(0), 32'sd0, 32'sd0);
    send_point(ADDR_W'(1), 32'sd2, 32'sd1);
    send_point(ADDR_W'(2), 32'sd4, -32'sd2);
    write_reg(CFG_POINT_COUNT, 3);
    send_query(32'sd1);
    send_query(32'sd3);
    write_reg(CFG_POINT_COUNT, 4);
    send_query(32'sd2);
    write_reg(CFG_POINT_COUNT, 0);
    send_query(32'sd2);
    write_reg(CFG_POINT_COUNT, 1);
    send_query(32'sd2);
    write_reg(CFG_POINT_COUNT, TABLE_DEPTH + 1);
    send_query(32'sd2);
    write_reg(CFG_POINT_COUNT, 32'hFFFF_FFFF);
    send_query(32'sd2);
    write_reg(CFG_POINT_COUNT, 32'hFFFF_F803);
    for (k = 0; k < 4; k++) write_reg(CFG_IDX_W'(CFG_POINT_COUNT + 1 + k), $urandom);
    send_query(32'sd2);
  endtask

  // random tables, mostly small, with random registers
  task automatic test_random_tables();
    int words, n, cnt, k, i;
    words = 0;
    while (words < RANDOM_WORDS) begin
      k = $urandom_range(0, 99);
      if (k < 70) n = $urandom_range(2, 8);
      else if (k < 95) n = $urandom_range(9, 40);
      else n = $urandom_range(41, 128);
      write_reg(CFG_PAD_MODE, $urandom);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_LEFT_PAD, $urandom);
        write_reg(CFG_RIGHT_PAD, $urandom);
      end
      k = $urandom_range(0, 99);
      if (k < 80) cnt = n;
      else if (k < 90) cnt = $urandom_range(2, n);
      else if (k < 95) cnt = n + 1;
      else cnt = $urandom;
      write_reg(CFG_POINT_COUNT, cnt);
      load_table(n, ($urandom_range(0, 99) < 30) ? 8 : 0);
      k = $urandom_range(3, 12);
      for (i = 0; i < k; i++) send_query(pick_query_time());
      words += n + k;
    end
  endtask

  // a large table, many search steps per query
  task automatic test_large_table();
    write_reg(CFG_PAD_MODE, DATA_W'(PAD_TABLE));
    write_reg(CFG_POINT_COUNT, LARGE_POINTS);
    load_table(LARGE_POINTS, 0);
    repeat (30) send_query(pick_query_time());
  endtask

  // long stretch without idle cycles on either side
  task automatic test_back_to_back();
    drain_results();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_PAD_MODE, DATA_W'(PAD_NONE));
    write_reg(CFG_POINT_COUNT, 16);
    load_table(16, 0);
    repeat (40) send_query(pick_query_time());
    drain_results();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_padding_modes();
    test_order_and_count();
    test_random_tables();
    test_large_table();
    test_back_to_back();
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tli_pkg.sv
hw/rtl/tli_ctrl.sv
hw/rtl/tli_dp.sv
hw/rtl/table_linear_interpolator.sv
hw/rtl/tli_checker.sv
tb/sv/tb_table_linear_interpolator.sv
